// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the encoder speed measure unit.
// Used by the top level; clock and reset are clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, a, b)
`define ASSERT_NEXT(label, a, b)
`endif
`endif

// ===== hw/rtl/esm_pkg.sv =====
// Shared types, constants and helpers of the encoder speed measure unit.
// No dependencies.
package esm_pkg;
	localparam int TIME_WIDTH_DEF = 32;
	localparam int DIV_W = 64;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [27:0] SCALE_Q8 = 28'd256000000;
	localparam logic [31:0] WINDOW_RESET = 32'd20000;

	localparam logic [2:0] MODE_EDGE = 3'd0;
	localparam logic [2:0] MODE_QUERY = 3'd1;
	localparam logic [2:0] MODE_IDLE = 3'd2;
	localparam logic [2:0] MODE_CLR_DIST = 3'd3;
	localparam logic [2:0] MODE_CLR_DISP = 3'd4;

	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_IDLE = 1'b1;

	typedef enum logic [2:0] {
		OP_EDGE, OP_QUERY, OP_IDLE, OP_CLR_DIST, OP_CLR_DISP, OP_NOP
	} op_t;

	typedef struct packed {
		op_t op;
		logic [31:0] now;
		logic rev;
	} cmd_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic wait_div;
		logic pop;
	} back_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
	} st_t;

	function automatic logic [31:0] sat32(input logic signed [65:0] v);
		logic [31:0] r;
		if (v > 66'sd2147483647) r = 32'h7FFF_FFFF;
		else if (v < -66'sd2147483648) r = 32'h8000_0000;
		else r = v[31:0];
		return r;
	endfunction
endpackage

// ===== hw/rtl/esm_front.sv =====
// Front end: accepts stream requests and decodes the mode into a command.
// Depends on esm_pkg.
module esm_front (
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [39:0]    s_tdata,  // [31:0] now_us, [32] b_level, rest zero
	input  logic [2:0]     s_tuser,  // [2:0] mode
	input  logic           q_full,
	output logic           push,
	output esm_pkg::cmd_t  cmd
);
	import esm_pkg::*;

	logic unused_pad;

	assign unused_pad = |s_tdata[39:33];
	assign s_tready = !q_full;
	assign push = s_tvalid && !q_full;

	always_comb begin
		cmd.now = s_tdata[31:0];
		cmd.rev = s_tdata[32] | (unused_pad & 1'b0);
		case (s_tuser)
			MODE_EDGE:     cmd.op = OP_EDGE;
			MODE_QUERY:    cmd.op = OP_QUERY;
			MODE_IDLE:     cmd.op = OP_IDLE;
			MODE_CLR_DIST: cmd.op = OP_CLR_DIST;
			MODE_CLR_DISP: cmd.op = OP_CLR_DISP;
			default:       cmd.op = OP_NOP;
		endcase
	end
endmodule

// ===== hw/rtl/esm_queue.sv =====
// Short command queue between front and back.
// Depends on esm_pkg.
module esm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  esm_pkg::cmd_t  push_cmd,
	input  logic           pop,
	output esm_pkg::cmd_t  head,
	output logic           empty,
	output logic           full
);
	import esm_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// ===== hw/rtl/esm_div.sv =====
// Sequential unsigned divider, two quotient bits per cycle.
// Depends on esm_pkg.
module esm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  esm_pkg::div_req_t          req,
	output logic                       busy,
	output logic                       done,
	output logic [esm_pkg::DIV_W-1:0]  quotient
);
	import esm_pkg::*;

	localparam int CW = $clog2(DIV_W / 2);

	logic [DIV_W-1:0] rem_q, quo_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [DIV_W:0] r1, r2;
	logic [DIV_W-1:0] m1, m2;
	logic b1, b2;

	always_comb begin
		r1 = {rem_q, quo_q[DIV_W-1]};
		b1 = (r1 >= {1'b0, dvs_q});
		m1 = b1 ? DIV_W'(r1 - {1'b0, dvs_q}) : r1[DIV_W-1:0];
		r2 = {m1, quo_q[DIV_W-2]};
		b2 = (r2 >= {1'b0, dvs_q});
		m2 = b2 ? DIV_W'(r2 - {1'b0, dvs_q}) : r2[DIV_W-1:0];
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= m2;
			quo_q <= {quo_q[DIV_W-3:0], b1, b2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== hw/rtl/esm_back.sv =====
// Back end: counters, window timing, speed sequencer and output register.
// Depends on esm_pkg; drives the shared divider esm_div.
module esm_back #(
	parameter int TIME_WIDTH = esm_pkg::TIME_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [31:0]                cfg_data,
	input  esm_pkg::cmd_t              cmd,
	input  logic                       cmd_valid,
	output esm_pkg::back_stat_t        stat,
	output esm_pkg::div_req_t          div_req,
	input  logic                       div_done,
	input  logic [esm_pkg::DIV_W-1:0]  div_quo,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [159:0]               m_tdata,
	output logic [1:0]                 m_tuser
);
	import esm_pkg::*;

	st_t st_q, st_d;
	logic [31:0] win_q, idle_q, pulses_q, total_q, net_q, speed_q, restarts_q, est_q;
	logic [TIME_WIDTH-1:0] ws_q, now_q, len_q;
	op_t op_q;
	logic close_q, phase_q, upd_q, idl_q;
	logic signed [65:0] t1_q;
	logic signed [64:0] prod_q;
	logic out_valid_q;
	logic [159:0] out_data_q;
	logic [1:0] out_user_q;

	logic [TIME_WIDTH-1:0] now_in, len_in;
	logic len_gt_win, len_gt_idle, big;
	logic [31:0] w_eff, rem32, spd_new;
	logic signed [31:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] q_signed;
	logic out_load;

	assign now_in = TIME_WIDTH'(cmd.now);
	assign len_in = now_in - ws_q;
	assign len_gt_win = (DIV_W'(len_in) > DIV_W'(win_q));
	assign len_gt_idle = (idle_q != '0) && (DIV_W'(len_in) > DIV_W'(idle_q));
	assign w_eff = (win_q == '0) ? 32'd1 : win_q;
	assign rem32 = (DIV_W'(len_q) <= DIV_W'(w_eff)) ? (w_eff - 32'(len_q)) : 32'd0;
	assign big = (TIME_WIDTH == DIV_W) && len_q[TIME_WIDTH-1];
	assign mul_a = phase_q ? signed'(speed_q) : signed'(pulses_q);
	assign mul_b = phase_q ? signed'({1'b0, rem32}) : signed'(33'(SCALE_Q8));
	assign q_signed = prod_q[64] ? -signed'({2'b00, div_quo}) : signed'({2'b00, div_quo});
	assign spd_new = big ? 32'd0 : sat32(q_signed);
	assign out_load = (st_q == ST_OUT) && (!out_valid_q || m_tready);

	assign div_req.start = (st_q == ST_DIV_GO);
	assign div_req.dividend = prod_q[64] ? DIV_W'(-prod_q) : DIV_W'(prod_q);
	assign div_req.divisor = close_q ? DIV_W'(len_q) : DIV_W'(w_eff);
	assign stat.wait_div = (st_q == ST_DIV_WAIT);
	assign stat.pop = (st_q == ST_IDLE) && cmd_valid;

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op == OP_QUERY || (cmd.op == OP_EDGE && len_gt_win)) st_d = ST_MUL;
					else st_d = ST_OUT;
				end
			end
			ST_MUL: st_d = ST_DIV_GO;
			ST_DIV_GO: st_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) st_d = (close_q || phase_q) ? ST_OUT : ST_MUL;
			end
			ST_OUT: begin
				if (out_load) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				op_q <= cmd.op;
				now_q <= now_in;
				len_q <= len_in;
				close_q <= len_gt_win;
				phase_q <= 1'b0;
			end
			ST_MUL: prod_q <= mul_a * mul_b;
			ST_DIV_WAIT: begin
				if (div_done && !close_q && !phase_q) begin
					t1_q <= q_signed;
					phase_q <= 1'b1;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_data_q <= {restarts_q, est_q, speed_q, net_q, total_q};
			out_user_q <= {idl_q, upd_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WINDOW_RESET;
			idle_q <= '0;
			ws_q <= '0;
			pulses_q <= '0;
			total_q <= '0;
			net_q <= '0;
			speed_q <= '0;
			restarts_q <= '0;
			est_q <= '0;
			upd_q <= 1'b0;
			idl_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WINDOW) win_q <= cfg_data;
				else idle_q <= cfg_data;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (st_q == ST_IDLE && cmd_valid) begin
				upd_q <= 1'b0;
				idl_q <= 1'b0;
				est_q <= '0;
				case (cmd.op)
					OP_EDGE: begin
						total_q <= total_q + 32'd1;
						net_q <= net_q + (cmd.rev ? 32'hFFFF_FFFF : 32'd1);
						pulses_q <= pulses_q + (cmd.rev ? 32'hFFFF_FFFF : 32'd1);
					end
					OP_IDLE: begin
						if (len_gt_idle) begin
							speed_q <= '0;
							pulses_q <= '0;
							ws_q <= now_in;
							idl_q <= 1'b1;
						end
					end
					OP_CLR_DIST: total_q <= '0;
					OP_CLR_DISP: net_q <= '0;
					default: ;
				endcase
			end
			if (st_q == ST_DIV_WAIT && div_done) begin
				if (close_q) begin
					speed_q <= spd_new;
					ws_q <= now_q;
					pulses_q <= '0;
					upd_q <= 1'b1;
					if (op_q == OP_QUERY) est_q <= spd_new;
					if (op_q == OP_EDGE) restarts_q <= restarts_q + 32'd1;
				end else if (phase_q) begin
					est_q <= sat32(t1_q + q_signed);
				end
			end
		end
	end
endmodule

// ===== hw/rtl/encoder_speed_measure_unit.sv =====
// Encoder speed measure unit: edge counting, windowed speed, speed estimate.
// Counting and clear items go straight to the output register; an item that closes a
// window takes one divider pass and a speed estimate two, on the shared 64-bit divider
// that resolves two quotient bits per cycle. The back end takes a new item only once the
// last one has been loaded into the output register, which waits on m_tready.
// Reset is asynchronous, active low; counters clear, window_us returns to 20000.
`include "assert_macros.svh"
module encoder_speed_measure_unit #(
	parameter int TIME_WIDTH = esm_pkg::TIME_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [39:0]   s_tdata,   // [31:0] now_us, [32] b_level, [39:33] zero
	input  logic [2:0]    s_tuser,   // [2:0] mode
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [159:0]  m_tdata,   // distance_count, displacement_count, last_speed,
	                                 // estimated_speed, window_restarts (32 bits each)
	output logic [1:0]    m_tuser,   // [0] speed_updated, [1] idled
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [31:0]   cfg_data
);
	import esm_pkg::*;

	cmd_t front_cmd, head_cmd;
	logic push, q_full, q_empty, div_busy, div_done;
	back_stat_t stat;
	div_req_t div_req;
	logic [DIV_W-1:0] div_quo;

	assign cfg_ready = 1'b1;

	esm_front u_front (
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.q_full(q_full), .push(push), .cmd(front_cmd)
	);

	esm_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_cmd(front_cmd),
		.pop(stat.pop), .head(head_cmd), .empty(q_empty), .full(q_full)
	);

	esm_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .busy(div_busy),
		.done(div_done), .quotient(div_quo)
	);

	esm_back #(.TIME_WIDTH(TIME_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(head_cmd), .cmd_valid(!q_empty), .stat(stat),
		.div_req(div_req), .div_done(div_done), .div_quo(div_quo),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	`ASSERT_IMPLY(a_done_when_waiting, div_done, stat.wait_div)
	`ASSERT_IMPLY(a_start_when_free, div_req.start, !div_busy)
	`ASSERT_IMPLY(a_pop_not_empty, stat.pop, !q_empty)
	`ASSERT_NEXT(a_start_busy, div_req.start, div_busy)
endmodule
